### rtl/opet_pkg.sv
// Shared types and default sizes for the overlap pair event tracker.
`timescale 1ns / 1ps
`default_nettype none

package opet_pkg;

  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned HandleBitsDef   = 16;

  typedef enum logic [1:0] {
    MODE_REPORT    = 2'd0,
    MODE_END_FRAME = 2'd1,
    MODE_REMOVE    = 2'd2,
    MODE_QUERY     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_ENTER = 3'd1,
    KIND_STAY  = 3'd2,
    KIND_EXIT  = 3'd3,
    KIND_FULL  = 3'd4
  } kind_e;

endpackage

`default_nettype wire

### rtl/overlap_pair_event_tracker_top.sv
// Overlap pair table with report, end-of-frame, remove and query commands.
// Every command walks all TABLE_ENTRIES slots, one slot per cycle through the
// single read port of the handle memory; its last result comes out as busy_o
// drops, and the next start is taken as soon as busy_o is low. Walk events
// come out only for slots that produce one, each held back until the next one
// arrives, the last one as the final result; the receiver cannot stall them.
// Reset clears the slot flags at once; the handle memory needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module overlap_pair_event_tracker_top import opet_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned HANDLE_BITS   = HandleBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic [HANDLE_BITS-1:0] handle_a_i,
  input  wire logic [HANDLE_BITS-1:0] handle_b_i,
  output logic                        event_valid_o,
  output logic [2:0]                  event_kind_o,
  output logic [HANDLE_BITS-1:0]      event_trigger_o,
  output logic [HANDLE_BITS-1:0]      event_other_o,
  output logic                        overlapping_o,
  output logic                        last_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam int unsigned PairW = 2 * HANDLE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  mode_e mode_q, mode_d;
  logic [HANDLE_BITS-1:0] a_q, a_d, b_q, b_d;

  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [TABLE_ENTRIES-1:0] entered_q, entered_d;
  logic [TABLE_ENTRIES-1:0] seen_q, seen_d;

  logic [PairW-1:0] mem_q [TABLE_ENTRIES];
  logic [PairW-1:0] rdata_q;
  logic             mem_we;

  logic            rd_act_q, rd_act_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            ev_vld_q, ev_vld_d;
  logic [IdxW-1:0] ev_idx_q, ev_idx_d;
  logic            ev_last_q, ev_last_d;

  logic                   match_q, match_d;
  logic [IdxW-1:0]        match_idx_q, match_idx_d;
  logic [HANDLE_BITS-1:0] match_t_q, match_t_d, match_o_q, match_o_d;
  logic                   free_q, free_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;

  logic                   pend_q, pend_d;
  kind_e                  pend_kind_q, pend_kind_d;
  logic [HANDLE_BITS-1:0] pend_t_q, pend_t_d, pend_o_q, pend_o_d;

  logic                   strobe_q, strobe_d;
  kind_e                  kind_q, kind_d;
  logic [HANDLE_BITS-1:0] trig_q, trig_d, oth_q, oth_d;
  logic                   ovl_q, ovl_d;
  logic                   last_q, last_d;

  logic [HANDLE_BITS-1:0] cur_t, cur_o;
  logic                   cur_valid, cur_entered, cur_seen, cur_hit;
  logic                   ev_has;
  kind_e                  ev_kind;

  assign cur_t       = rdata_q[PairW-1:HANDLE_BITS];
  assign cur_o       = rdata_q[HANDLE_BITS-1:0];
  assign cur_valid   = valid_q[ev_idx_q];
  assign cur_entered = entered_q[ev_idx_q];
  assign cur_seen    = seen_q[ev_idx_q];
  assign cur_hit     = cur_valid && (((cur_t == a_q) && (cur_o == b_q)) ||
                                     ((cur_t == b_q) && (cur_o == a_q)));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    a_d         = a_q;
    b_d         = b_q;
    valid_d     = valid_q;
    entered_d   = entered_q;
    seen_d      = seen_q;
    mem_we      = 1'b0;
    rd_act_d    = rd_act_q;
    rd_idx_d    = rd_idx_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = ev_idx_q;
    ev_last_d   = 1'b0;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_t_d   = match_t_q;
    match_o_d   = match_o_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    pend_t_d    = pend_t_q;
    pend_o_d    = pend_o_q;
    strobe_d    = 1'b0;
    kind_d      = kind_q;
    trig_d      = trig_q;
    oth_d       = oth_q;
    ovl_d       = ovl_q;
    last_d      = 1'b0;
    ev_has      = 1'b0;
    ev_kind     = KIND_NONE;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d  = S_SCAN;
          mode_d   = mode_e'(mode_i);
          a_d      = handle_a_i;
          b_d      = handle_b_i;
          rd_act_d = 1'b1;
          rd_idx_d = '0;
          match_d  = 1'b0;
          free_d   = 1'b0;
          pend_d   = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_act_q) begin
          ev_vld_d  = 1'b1;
          ev_idx_d  = rd_idx_q;
          ev_last_d = (rd_idx_q == LastIdx);
          if (rd_idx_q == LastIdx) begin
            rd_act_d = 1'b0;
            rd_idx_d = '0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (ev_vld_q) begin
          unique case (mode_q)
            MODE_REPORT, MODE_QUERY: begin
              if (cur_hit && !match_q) begin
                match_d     = 1'b1;
                match_idx_d = ev_idx_q;
                match_t_d   = cur_t;
                match_o_d   = cur_o;
              end
              if (!cur_valid && !free_q) begin
                free_d     = 1'b1;
                free_idx_d = ev_idx_q;
              end
            end
            MODE_END_FRAME: begin
              if (cur_valid) begin
                if (!cur_seen) begin
                  ev_has              = cur_entered;
                  ev_kind             = KIND_EXIT;
                  valid_d[ev_idx_q]   = 1'b0;
                  entered_d[ev_idx_q] = 1'b0;
                end else begin
                  ev_has              = 1'b1;
                  ev_kind             = cur_entered ? KIND_STAY : KIND_ENTER;
                  entered_d[ev_idx_q] = 1'b1;
                  seen_d[ev_idx_q]    = 1'b0;
                end
              end
            end
            MODE_REMOVE: begin
              if (cur_valid && ((cur_t == a_q) || (cur_o == a_q))) begin
                ev_has              = cur_entered;
                ev_kind             = KIND_EXIT;
                valid_d[ev_idx_q]   = 1'b0;
                entered_d[ev_idx_q] = 1'b0;
                seen_d[ev_idx_q]    = 1'b0;
              end
            end
          endcase
          if (ev_has) begin
            if (pend_q) begin
              strobe_d = 1'b1;
              kind_d   = pend_kind_q;
              trig_d   = pend_t_q;
              oth_d    = pend_o_q;
              ovl_d    = 1'b0;
            end
            pend_d      = 1'b1;
            pend_kind_d = ev_kind;
            pend_t_d    = cur_t;
            pend_o_d    = cur_o;
          end
          if (ev_last_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        state_d  = S_IDLE;
        strobe_d = 1'b1;
        last_d   = 1'b1;
        ovl_d    = 1'b0;
        unique case (mode_q)
          MODE_REPORT: begin
            if (match_q) begin
              seen_d[match_idx_q] = 1'b1;
              kind_d = KIND_NONE;
              trig_d = match_t_q;
              oth_d  = match_o_q;
            end else if (free_q) begin
              mem_we                = 1'b1;
              valid_d[free_idx_q]   = 1'b1;
              entered_d[free_idx_q] = 1'b0;
              seen_d[free_idx_q]    = 1'b1;
              kind_d = KIND_NONE;
              trig_d = a_q;
              oth_d  = b_q;
            end else begin
              kind_d = KIND_FULL;
              trig_d = a_q;
              oth_d  = b_q;
            end
          end
          MODE_QUERY: begin
            kind_d = KIND_NONE;
            ovl_d  = match_q;
            trig_d = match_q ? match_t_q : a_q;
            oth_d  = match_q ? match_o_q : b_q;
          end
          MODE_END_FRAME, MODE_REMOVE: begin
            kind_d = pend_q ? pend_kind_q : KIND_NONE;
            trig_d = pend_q ? pend_t_q : '0;
            oth_d  = pend_q ? pend_o_q : '0;
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[free_idx_q] <= {a_q, b_q};
    end
    rdata_q <= mem_q[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      entered_q <= '0;
      seen_q    <= '0;
      rd_act_q  <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_last_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      pend_q    <= 1'b0;
      strobe_q  <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      entered_q <= entered_d;
      seen_q    <= seen_d;
      rd_act_q  <= rd_act_d;
      ev_vld_q  <= ev_vld_d;
      ev_last_q <= ev_last_d;
      match_q   <= match_d;
      free_q    <= free_d;
      pend_q    <= pend_d;
      strobe_q  <= strobe_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    a_q         <= a_d;
    b_q         <= b_d;
    rd_idx_q    <= rd_idx_d;
    ev_idx_q    <= ev_idx_d;
    match_idx_q <= match_idx_d;
    match_t_q   <= match_t_d;
    match_o_q   <= match_o_d;
    free_idx_q  <= free_idx_d;
    pend_kind_q <= pend_kind_d;
    pend_t_q    <= pend_t_d;
    pend_o_q    <= pend_o_d;
    kind_q      <= kind_d;
    trig_q      <= trig_d;
    oth_q       <= oth_d;
    ovl_q       <= ovl_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign event_valid_o   = strobe_q;
  assign event_kind_o    = kind_q;
  assign event_trigger_o = trig_q;
  assign event_other_o   = oth_q;
  assign overlapping_o   = ovl_q;
  assign last_o          = last_q;

endmodule

`default_nettype wire
